>>> src/nmul_pkg.sv
`default_nettype none
package nmul_pkg;

  // Number of coefficients per polynomial; must be a power of two
  localparam int POLY_DEGREE = 256;
  localparam int IDX_W       = $clog2(POLY_DEGREE);
  localparam int CNT_W       = IDX_W + 1;

  localparam int COEFF_W = 16;
  localparam int PROD_W  = 2 * COEFF_W;
  localparam int ACC_W   = 48;
  localparam int Q_W     = 14;
  localparam int DQ_W    = Q_W + 1;
  localparam int RES_W   = 15;

  typedef struct packed {
    logic                      func;
    logic signed [COEFF_W-1:0] a_coeff;
    logic signed [COEFF_W-1:0] b_coeff;
  } in_item_t;

  typedef struct packed {
    logic signed [RES_W-1:0] coeff;
    logic                    last;
    logic                    not_ready;
  } out_item_t;

  // Tag riding alongside one multiply-accumulate term
  typedef struct packed {
    logic             valid;
    logic             neg;    // term wraps past x^N, subtract
    logic             first;  // first term of an output coefficient
    logic             last;   // final term, write the sum back
    logic [IDX_W-1:0] addr;   // output coefficient index
  } mac_tag_t;

endpackage
`default_nettype wire

>>> src/negacyclic_poly_mul_mod_2q_core.sv
// Negacyclic schoolbook multiplier, product modulo x^N+1 (N = POLY_DEGREE,
// power of two), results centred modulo 2q into (-q, q]. Loads (func 0) fill
// the two factor RAMs in index order. The N-th load starts the product:
// one 16x16 MAC walks every output coefficient over all N terms, and no
// request is taken until the product is complete. Reads (func 1) fetch
// one accumulator from RAM and pass it through a bit-serial modulo unit;
// a read before the product is complete answers at once with not_ready
// set. A load after a finished product or the final read starts a new
// polynomial, any other load continues the one being loaded. One request
// is handled at a time and a read waits until the previous result has
// been taken. cfg writes are accepted every cycle.
`default_nettype none
module negacyclic_poly_mul_mod_2q_core
  import nmul_pkg::*;
(
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire logic           in_valid,
  output logic                in_ready,
  input  wire in_item_t       in_data,
  output logic                out_valid,
  input  wire logic           out_ready,
  output out_item_t           out_data,
  input  wire logic           cfg_valid,
  output logic                cfg_ready,
  input  wire logic [Q_W-1:0] cfg_data
);

  typedef enum logic [4:0] {
    ST_IDLE  = 5'b00001,
    ST_COMP  = 5'b00010,
    ST_DRAIN = 5'b00100,
    ST_RDMEM = 5'b01000,
    ST_RED   = 5'b10000
  } state_t;

  localparam logic [IDX_W-1:0] IDX_MAX = IDX_W'(POLY_DEGREE - 1);

  state_t state_r, state_nxt;

  logic [Q_W-1:0]   modulus_q_r;
  logic [CNT_W-1:0] load_count_r;
  logic [IDX_W-1:0] read_ptr_r;
  logic             result_ready_r;
  logic             rd_last_r;
  logic [IDX_W-1:0] s_r;
  logic [IDX_W-1:0] i_r;
  mac_tag_t         tag1_r;

  logic             out_valid_r;
  out_item_t        out_data_r;

  // Memories
  logic signed [COEFF_W-1:0] a_mem [POLY_DEGREE];
  logic signed [COEFF_W-1:0] b_mem [POLY_DEGREE];
  logic signed [ACC_W-1:0]   acc_mem [POLY_DEGREE];
  logic signed [COEFF_W-1:0] a_q_r;
  logic signed [COEFF_W-1:0] b_q_r;
  logic signed [ACC_W-1:0]   acc_q_r;

  logic             accept;
  logic             ld_req;
  logic             rd_req;
  logic [IDX_W-1:0] ld_idx;
  logic [IDX_W-1:0] b_addr;
  mac_tag_t         tag1_nxt;

  logic                    mac_wr_en;
  logic [IDX_W-1:0]        mac_wr_addr;
  logic signed [ACC_W-1:0] mac_wr_data;
  logic                    mac_busy;

  logic                    red_start;
  logic                    red_done;
  logic signed [RES_W-1:0] red_res;

  assign in_ready  = (state_r == ST_IDLE) && !out_valid_r;
  assign accept    = in_valid && in_ready;
  assign ld_req    = accept && !in_data.func;
  assign rd_req    = accept && in_data.func;
  assign cfg_ready = 1'b1;

  // A load after a finished product starts over at index 0
  assign ld_idx = result_ready_r ? '0 : load_count_r[IDX_W-1:0];

  // Term a[i]*b[s-i]; index wrap is mod N, past x^N the term is negated
  assign b_addr = s_r - i_r;

  always_comb begin
    tag1_nxt       = '0;
    tag1_nxt.valid = (state_r == ST_COMP);
    tag1_nxt.neg   = (i_r > s_r);
    tag1_nxt.first = (i_r == '0);
    tag1_nxt.last  = (i_r == IDX_MAX);
    tag1_nxt.addr  = s_r;
  end

  assign red_start = (state_r == ST_RDMEM);

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (ld_req && (ld_idx == IDX_MAX)) begin
          state_nxt = ST_COMP;
        end else if (rd_req && result_ready_r) begin
          state_nxt = ST_RDMEM;
        end
      end
      ST_COMP: begin
        if ((s_r == IDX_MAX) && (i_r == IDX_MAX)) begin
          state_nxt = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        if (!tag1_r.valid && !mac_busy) begin
          state_nxt = ST_IDLE;
        end
      end
      ST_RDMEM: state_nxt = ST_RED;
      ST_RED: begin
        if (red_done) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r        <= ST_IDLE;
      modulus_q_r    <= Q_W'(3329);
      load_count_r   <= '0;
      read_ptr_r     <= '0;
      result_ready_r <= 1'b0;
      s_r            <= '0;
      i_r            <= '0;
      tag1_r         <= '0;
      out_valid_r    <= 1'b0;
    end else begin
      state_r <= state_nxt;
      tag1_r  <= tag1_nxt;
      if (cfg_valid && cfg_ready) begin
        modulus_q_r <= cfg_data;
      end
      if (out_valid_r && out_ready) begin
        out_valid_r <= 1'b0;
      end

      if (ld_req) begin
        result_ready_r <= 1'b0;
        read_ptr_r     <= '0;
        load_count_r   <= CNT_W'(ld_idx) + 1'b1;
        s_r            <= '0;
        i_r            <= '0;
      end

      if (rd_req) begin
        if (!result_ready_r) begin
          out_valid_r <= 1'b1;
        end else if (read_ptr_r == IDX_MAX) begin
          result_ready_r <= 1'b0;
          load_count_r   <= '0;
          read_ptr_r     <= '0;
        end else begin
          read_ptr_r <= read_ptr_r + 1'b1;
        end
      end

      if (state_r == ST_COMP) begin
        i_r <= i_r + 1'b1;
        if (i_r == IDX_MAX) begin
          s_r <= s_r + 1'b1;
        end
      end

      if ((state_r == ST_DRAIN) && (state_nxt == ST_IDLE)) begin
        result_ready_r <= 1'b1;
        read_ptr_r     <= '0;
      end

      if ((state_r == ST_RED) && red_done) begin
        out_valid_r <= 1'b1;
      end
    end
  end

  // Output payload
  always_ff @(posedge clk) begin
    if (rd_req) begin
      rd_last_r <= (read_ptr_r == IDX_MAX);
      if (!result_ready_r) begin
        out_data_r.coeff     <= '0;
        out_data_r.last      <= 1'b0;
        out_data_r.not_ready <= 1'b1;
      end
    end
    if ((state_r == ST_RED) && red_done) begin
      out_data_r.coeff     <= red_res;
      out_data_r.last      <= rd_last_r;
      out_data_r.not_ready <= 1'b0;
    end
  end

  // Factor RAMs
  always_ff @(posedge clk) begin
    if (ld_req) begin
      a_mem[ld_idx] <= in_data.a_coeff;
      b_mem[ld_idx] <= in_data.b_coeff;
    end
    a_q_r <= a_mem[i_r];
    b_q_r <= b_mem[b_addr];
  end

  // Accumulator RAM
  always_ff @(posedge clk) begin
    if (mac_wr_en) begin
      acc_mem[mac_wr_addr] <= mac_wr_data;
    end
    acc_q_r <= acc_mem[read_ptr_r];
  end

  nmul_mac u_mac (
    .clk       (clk),
    .rst_n     (rst_n),
    .tag_i     (tag1_r),
    .a_i       (a_q_r),
    .b_i       (b_q_r),
    .wr_en_o   (mac_wr_en),
    .wr_addr_o (mac_wr_addr),
    .wr_data_o (mac_wr_data),
    .busy_o    (mac_busy)
  );

  nmul_reduce u_reduce (
    .clk     (clk),
    .rst_n   (rst_n),
    .start_i (red_start),
    .val_i   (acc_q_r),
    .q_i     (modulus_q_r),
    .done_o  (red_done),
    .res_o   (red_res)
  );

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // Checks
  a_nr_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_data_r.not_ready) |-> (out_data_r.coeff == '0 && !out_data_r.last))
    else $error("not_ready result carries data");

  a_wr_comp: assert property (@(posedge clk) disable iff (!rst_n)
    mac_wr_en |-> (state_r == ST_COMP || state_r == ST_DRAIN))
    else $error("accumulator write outside product pass");

  a_red_done: assert property (@(posedge clk) disable iff (!rst_n)
    red_done |-> (state_r == ST_RED))
    else $error("modulo unit finished outside read");

  a_ready_cnt: assert property (@(posedge clk) disable iff (!rst_n)
    result_ready_r |-> (load_count_r == CNT_W'(POLY_DEGREE)))
    else $error("results ready without full load");

endmodule
`default_nettype wire

>>> src/nmul_mac.sv
`default_nettype none
module nmul_mac
  import nmul_pkg::*;
(
  input  wire logic                      clk,
  input  wire logic                      rst_n,
  input  wire mac_tag_t                  tag_i,
  input  wire logic signed [COEFF_W-1:0] a_i,
  input  wire logic signed [COEFF_W-1:0] b_i,
  output logic                           wr_en_o,
  output logic [IDX_W-1:0]               wr_addr_o,
  output logic signed [ACC_W-1:0]        wr_data_o,
  output logic                           busy_o
);

  mac_tag_t                 tag_r;
  logic signed [PROD_W-1:0] prod_r;
  logic signed [PROD_W-1:0] prod_nxt;
  logic signed [ACC_W-1:0]  acc_r;
  logic signed [ACC_W-1:0]  acc_nxt;
  logic signed [ACC_W-1:0]  acc_base;
  logic signed [ACC_W-1:0]  prod_ext;

  assign prod_nxt = PROD_W'(a_i) * PROD_W'(b_i);
  assign prod_ext = ACC_W'(prod_r);
  assign acc_base = tag_r.first ? '0 : acc_r;
  assign acc_nxt  = tag_r.neg ? (acc_base - prod_ext) : (acc_base + prod_ext);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tag_r <= '0;
    end else begin
      tag_r <= tag_i;
    end
  end

  always_ff @(posedge clk) begin
    prod_r <= prod_nxt;
    if (tag_r.valid) begin
      acc_r <= acc_nxt;
    end
  end

  assign wr_en_o   = tag_r.valid & tag_r.last;
  assign wr_addr_o = tag_r.addr;
  assign wr_data_o = acc_nxt;
  assign busy_o    = tag_r.valid;

endmodule
`default_nettype wire

>>> src/nmul_reduce.sv
`default_nettype none
module nmul_reduce
  import nmul_pkg::*;
(
  input  wire logic                    clk,
  input  wire logic                    rst_n,
  input  wire logic                    start_i,
  input  wire logic signed [ACC_W-1:0] val_i,
  input  wire logic [Q_W-1:0]          q_i,
  output logic                         done_o,
  output logic signed [RES_W-1:0]      res_o
);

  localparam int BIT_CNT_W = $clog2(ACC_W + 1);

  logic [ACC_W-1:0]     mag_r;
  logic [DQ_W:0]        rem_r;
  logic [DQ_W:0]        dq_r;
  logic [Q_W-1:0]       q_r;
  logic                 neg_r;
  logic                 busy_r;
  logic [BIT_CNT_W-1:0] cnt_r;
  logic                 done_r;
  logic signed [RES_W-1:0] res_r;

  logic [DQ_W:0]   rem_sh;
  logic [DQ_W:0]   rem_nxt;
  logic signed [DQ_W+1:0] pos_val;
  logic signed [DQ_W+1:0] cen_val;

  // Restoring remainder, one dividend bit per cycle
  assign rem_sh  = {rem_r[DQ_W-1:0], mag_r[ACC_W-1]};
  assign rem_nxt = (rem_sh >= dq_r) ? (rem_sh - dq_r) : rem_sh;

  always_comb begin
    pos_val = (neg_r && (rem_nxt != '0)) ? $signed({1'b0, dq_r - rem_nxt})
                                         : $signed({1'b0, rem_nxt});
    cen_val = (pos_val > $signed({3'b000, q_r})) ? (pos_val - $signed({1'b0, dq_r}))
                                                 : pos_val;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start_i) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
      end else if (busy_r) begin
        cnt_r <= cnt_r + 1'b1;
        if (cnt_r == BIT_CNT_W'(ACC_W - 1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start_i) begin
      mag_r <= val_i[ACC_W-1] ? (-val_i) : val_i;
      neg_r <= val_i[ACC_W-1];
      rem_r <= '0;
      q_r   <= q_i;
      dq_r  <= {1'b0, q_i, 1'b0};
    end else if (busy_r) begin
      mag_r <= {mag_r[ACC_W-2:0], 1'b0};
      rem_r <= rem_nxt;
      if (cnt_r == BIT_CNT_W'(ACC_W - 1)) begin
        res_r <= (q_r == '0) ? '0 : RES_W'(cen_val);
      end
    end
  end

  assign done_o = done_r;
  assign res_o  = res_r;

endmodule
`default_nettype wire

>>> tb/negacyclic_poly_mul_mod_2q_core_test.sv
`default_nettype none
// Checks the negacyclic multiplier against an in-bench predictor: factor
// loads, reads before the product is ready, the final read, partial loads
// afterwards, and centred reduction under several moduli (0, 1, 2, max).
module negacyclic_poly_mul_mod_2q_core_test;
  import nmul_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic FN_LOAD = 1'b0;
  localparam logic FN_READ = 1'b1;
  localparam int   PRODUCT_CYCLES = POLY_DEGREE * POLY_DEGREE + 100;

  logic            clk;
  logic            rst_n;
  logic            in_valid = 1'b0;
  logic            in_ready;
  in_item_t        in_data = '0;
  logic            out_valid;
  logic            out_ready = 1'b0;
  out_item_t       out_data;
  logic            cfg_valid;
  logic            cfg_ready;
  logic [Q_W-1:0]  cfg_data;

  negacyclic_poly_mul_mod_2q_core dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
    .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data)
  );

  always begin
    clk = 1'b1;
    #2;
    clk = 1'b0;
    #2;
  end

  // Pending requests, and results the predictor expects back
  in_item_t  request_q[$];
  out_item_t coeff_expect_q[$];

  // Predictor's copy of the block state
  logic signed [COEFF_W-1:0] fac_a [POLY_DEGREE];
  logic signed [COEFF_W-1:0] fac_b [POLY_DEGREE];
  longint                    prod_acc [POLY_DEGREE];
  int                        loaded = 0;
  int                        rd_idx = 0;
  bit                        prod_done = 0;
  logic [Q_W-1:0]            mod_q = 14'd3329;

  int  mismatches = 0;
  int  req_taken = 0;
  int  res_taken = 0;
  int  not_ready_seen = 0;
  int  last_seen = 0;
  int  products_formed = 0;
  bit  in_fire;
  bit  last_was_load = 0;

  // Folded schoolbook product modulo x^N + 1, exact 64-bit sums
  function automatic void form_negacyclic_product();
    longint p;
    for (int k = 0; k < POLY_DEGREE; k++) prod_acc[k] = 0;
    for (int i = 0; i < POLY_DEGREE; i++) begin
      for (int k = 0; k < POLY_DEGREE; k++) begin
        p = longint'(fac_a[i]) * longint'(fac_b[k]);
        if (i + k < POLY_DEGREE) prod_acc[i + k] += p;
        else prod_acc[i + k - POLY_DEGREE] -= p;
      end
    end
  endfunction

  // Centred remainder in (-q, q] modulo 2q; zero modulus gives zero
  function automatic longint centre_mod_2q(longint v);
    longint q;
    longint dq;
    longint r;
    q  = longint'(mod_q);
    dq = 2 * q;
    if (dq == 0) return 0;
    r = v % dq;
    if (r < 0) r += dq;
    if (r > q) r -= dq;
    return r;
  endfunction

  // Advance predictor by one accepted request
  function automatic void predict_request(in_item_t rq);
    out_item_t res;
    longint    r;
    if (rq.func == FN_LOAD) begin
      if (prod_done || loaded >= POLY_DEGREE) begin
        prod_done = 0;
        loaded    = 0;
        rd_idx    = 0;
      end
      fac_a[loaded] = rq.a_coeff;
      fac_b[loaded] = rq.b_coeff;
      loaded++;
      if (loaded == POLY_DEGREE) begin
        form_negacyclic_product();
        prod_done = 1;
        rd_idx    = 0;
        products_formed++;
      end
    end else begin
      res = '0;
      if (!prod_done) begin
        res.not_ready = 1'b1;
      end else begin
        r = centre_mod_2q(prod_acc[rd_idx]);
        res.coeff = r[RES_W-1:0];
        res.last  = (rd_idx == POLY_DEGREE - 1);
        rd_idx++;
        if (res.last) begin
          prod_done = 0;
          loaded    = 0;
          rd_idx    = 0;
        end
      end
      coeff_expect_q.push_back(res);
    end
  endfunction

  // Sample both handshakes at the rising edge: predict first, then check
  always @(posedge clk) begin
    out_item_t exp_res;
    in_fire = rst_n && in_valid && in_ready;
    if (in_fire) begin
      predict_request(in_data);
      req_taken++;
    end
    if (rst_n && out_valid && out_ready) begin
      res_taken++;
      if (coeff_expect_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected result coeff=%0d last=%0b not_ready=%0b",
                   out_data.coeff, out_data.last, out_data.not_ready);
      end else begin
        exp_res = coeff_expect_q.pop_front();
        if (exp_res.not_ready) not_ready_seen++;
        if (exp_res.last) last_seen++;
        if (out_data.coeff !== exp_res.coeff || out_data.last !== exp_res.last ||
            out_data.not_ready !== exp_res.not_ready) begin
          mismatches++;
          if (mismatches <= 10)
            $display("result %0d: expected coeff=%0d last=%0b not_ready=%0b, got %0d %0b %0b",
                     res_taken, exp_res.coeff, exp_res.last, exp_res.not_ready,
                     out_data.coeff, out_data.last, out_data.not_ready);
        end
      end
    end
  end

  // Request driver: idles about 23% of the time, except in a quiet stretch
  always @(negedge clk) begin
    bit quiet;
    quiet = (req_taken >= 300 && req_taken < 420);
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else if (!in_valid || in_fire) begin
      if (request_q.size() != 0 && (quiet || $urandom_range(0, 99) >= 23)) begin
        in_valid <= 1'b1;
        in_data  <= request_q.pop_front();
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // Result side: random back-pressure, one long hold-off and a stretch always ready
  int  hold_left = 0;
  bit  held_long = 0;
  always @(negedge clk) begin
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left <= hold_left - 1;
      out_ready <= 1'b0;
    end else if (!held_long && res_taken == 50) begin
      held_long <= 1'b1;
      hold_left <= 400;
      out_ready <= 1'b0;
    end else if (res_taken >= 100 && res_taken < 200) begin
      out_ready <= 1'b1;
    end else begin
      out_ready <= ($urandom_range(0, 99) >= 23);
    end
  end

  function automatic logic signed [COEFF_W-1:0] pick_coeff();
    case ($urandom_range(0, 7))
      0: return 16'sh8000;
      1: return 16'sh7fff;
      2: return '0;
      3: return -16'sd1;
      default: return COEFF_W'($urandom);
    endcase
  endfunction

  task automatic push_load(logic signed [COEFF_W-1:0] a, logic signed [COEFF_W-1:0] b);
    in_item_t rq;
    rq.func = FN_LOAD;
    rq.a_coeff = a;
    rq.b_coeff = b;
    request_q.push_back(rq);
    last_was_load = 1;
  endtask

  // Read requests carry random junk in the unused fields
  task automatic push_reads(int n);
    in_item_t rq;
    for (int i = 0; i < n; i++) begin
      rq.func = FN_READ;
      rq.a_coeff = COEFF_W'($urandom);
      rq.b_coeff = COEFF_W'($urandom);
      request_q.push_back(rq);
    end
    last_was_load = 0;
  endtask

  task automatic push_random_loads(int n);
    for (int i = 0; i < n; i++) push_load(pick_coeff(), pick_coeff());
  endtask

  // Sender pauses until every result is back and the block has gone quiet
  task automatic drain();
    wait (request_q.size() == 0);
    @(negedge clk);
    wait (!in_valid && coeff_expect_q.size() == 0);
    repeat (last_was_load ? PRODUCT_CYCLES : 100) @(negedge clk);
  endtask

  task automatic write_modulus(logic [Q_W-1:0] v);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_data  <= v;
    do @(posedge clk); while (!cfg_ready);
    mod_q = v;
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  logic [Q_W-1:0] moduli [8];

  initial begin
    rst_n = 1'b0;
    cfg_valid = 1'b0;
    cfg_data = '0;
    repeat (10) @(negedge clk);
    rst_n = 1'b1;

    // Directed: reads before anything is loaded, partial loads of extremes,
    // reads against a half-loaded polynomial
    push_reads(2);
    push_load(16'sh7fff, 16'sh8000);
    push_load(16'sh8000, 16'sh7fff);
    push_load(16'sh0000, -16'sd1);
    push_load(-16'sd1, 16'sh0000);
    push_load(16'sh5555, 16'shaaaa);
    push_reads(2);
    push_load(16'shaaaa, 16'sh5555);
    push_load(16'sh8000, 16'sh8000);
    push_reads(1);
    drain();
    write_modulus(14'd3329);

    // Full product continuing the partial load, read back under several
    // moduli including zero, one, two and the maximum
    push_random_loads(POLY_DEGREE - 7);
    drain();
    moduli = '{14'd16383, 14'd2, 14'd0, 14'd1, 14'd3329,
               14'($urandom_range(2, 16383)), 14'($urandom_range(2, 16383)),
               14'd16383};
    for (int c = 0; c < 8; c++) begin
      write_modulus(moduli[c]);
      push_reads(POLY_DEGREE / 8);
      drain();
    end
    push_reads(3);

    // After the final read: partial loads with refused reads between them
    push_random_loads(60);
    push_reads(10);
    push_random_loads(50);
    push_reads(10);
    drain();

    $display("covered %0d requests, %0d results, %0d products,",
             req_taken, res_taken, products_formed);
    $display("  %0d refused reads, %0d final reads", not_ready_seen, last_seen);
    if (mismatches == 0) begin
      $display("end of test: clean");
    end else begin
      $display("%0d mismatches in total", mismatches);
      $display("end of test: mismatches");
    end
    $finish;
  end

  initial begin
    #10ms;
    $display("timeout: %0d results still outstanding", coeff_expect_q.size());
    $display("end of test: mismatches");
    $finish;
  end

endmodule
`default_nettype wire
